// ----- rtl/weia_pkg.sv -----
// shared constants, types and helper functions for the windowed event interval average
// no dependencies

package weia_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int STREAM_COUNT = 3;

    localparam int STORE_DEPTH = STREAM_COUNT * RING_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int SIDX_W      = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

    localparam int TIME_W   = 32;
    localparam int WIN_W    = 16;
    localparam int STREAM_W = 2;
    localparam int FRAC_W   = 16;
    localparam int DVD_W    = TIME_W + FRAC_W;
    localparam int AVG_W    = 39;
    localparam int KEPT_W   = 7;

    localparam int MS_PER_S = 1000;
    localparam int DIVR_W   = $clog2((RING_DEPTH - 1) * MS_PER_S + 1);
    localparam int STEP_W   = $clog2(DVD_W + 1);

    localparam int KEEP_MIN     = 2;
    localparam int WINDOW_RESET = 100;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic       OP_RECORD  = 1'b0;
    localparam logic       OP_CLEAR   = 1'b1;
    localparam logic       REG_WINDOW = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(RING_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
                                                  input logic [CNT_W-1:0] c);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(p) + (CNT_W+1)'(c);
        if (sum >= (CNT_W+1)'(RING_DEPTH))
            sum = sum - (CNT_W+1)'(RING_DEPTH);
        return PTR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SIDX_W-1:0] s,
                                                    input logic [PTR_W-1:0]  pos);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(RING_DEPTH)) + ADDR_W'(pos);
    endfunction

endpackage

// ----- rtl/windowed_event_interval_average.sv -----
// top level: sequencer, ring pointers and counts, window register, output register
// depends on weia_pkg, weia_store, weia_div
//
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   opcode, stream, now_ms
// out       output     out_valid/out_stall avg_interval, kept_count
// apb       input      psel/penable/pready window_ms at byte address 0
//
// a record item writes its timestamp, then reads and compares the oldest ring entries in turn,
// dropping those older than the window while more than KEEP_MIN remain, then runs the 48-step divider
// clear and out-of-range items go straight to the done state, as does a lone entry after its write
// in_stall is high from acceptance until the result is loaded into the output register
// out_stall holds the output register; the next item is taken meanwhile
// no clearing pass after reset: ring counts start at zero

module windowed_event_interval_average
    import weia_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  logic [STREAM_W-1:0] stream,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [AVG_W-1:0]    avg_interval,
    output logic [KEPT_W-1:0]   kept_count,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_WRITE    = 6'b000010,
        ST_SCAN_RD  = 6'b000100,
        ST_SCAN_CMP = 6'b001000,
        ST_DIV_WAIT = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [WIN_W-1:0]  window_reg;
    logic [PTR_W-1:0]  ptr_arr [STREAM_COUNT];
    logic [CNT_W-1:0]  cnt_arr [STREAM_COUNT];

    logic [SIDX_W-1:0] stream_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] limit_reg, limit_next;
    logic [PTR_W-1:0]  cur_ptr_reg, cur_ptr_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic              active_reg, active_next;
    logic [AVG_W-1:0]  res_avg_reg, res_avg_next;
    logic [CNT_W-1:0]  res_cnt_reg, res_cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]  avg_reg;
    logic [KEPT_W-1:0] kept_reg;

    logic              in_accept;
    logic              stream_ok;
    logic [SIDX_W-1:0] in_sidx;
    logic              clear_all;
    logic              out_load;
    logic              ring_full;

    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [TIME_W-1:0] mem_rd_data;

    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DIVR_W-1:0] div_divisor;
    logic [AVG_W-1:0]  div_quotient;
    div_stat_t         div_stat;

    logic              cfg_write;

    weia_store u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (now_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    weia_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign stream_ok = 32'(stream) < STREAM_COUNT;
    assign in_sidx   = SIDX_W'(stream);
    assign ring_full = (cur_cnt_reg == CNT_W'(RING_DEPTH));
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    assign mem_wr_addr  = slot_addr(stream_reg,
                                    ring_full ? cur_ptr_reg : ring_add(cur_ptr_reg, cur_cnt_reg));
    assign mem_rd_addr  = slot_addr(stream_reg, cur_ptr_reg);
    assign div_dividend = {now_reg - mem_rd_data, FRAC_W'(0)};
    assign div_divisor  = DIVR_W'(32'(cur_cnt_reg - CNT_W'(1)) * MS_PER_S);

    always_comb
    begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        cur_ptr_next = cur_ptr_reg;
        cur_cnt_next = cur_cnt_reg;
        active_next  = active_reg;
        res_avg_next = res_avg_reg;
        res_cnt_next = res_cnt_reg;
        clear_all    = 1'b0;
        mem_wr_en    = 1'b0;
        mem_rd_en    = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_avg_next = '0;
                    res_cnt_next = '0;
                    active_next  = 1'b0;
                    if (opcode == OP_CLEAR)
                    begin
                        clear_all  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (!stream_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cur_ptr_next = ptr_arr[in_sidx];
                        cur_cnt_next = cnt_arr[in_sidx];
                        active_next  = 1'b1;
                        state_next   = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                mem_wr_en  = 1'b1;
                limit_next = now_reg - TIME_W'(window_reg);
                if (ring_full)
                begin
                    cur_ptr_next = ptr_inc(cur_ptr_reg);
                    state_next   = ST_SCAN_RD;
                end
                else
                begin
                    cur_cnt_next = cur_cnt_reg + CNT_W'(1);
                    if (cur_cnt_reg == '0)
                    begin
                        res_cnt_next = CNT_W'(1);
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (cur_cnt_reg > CNT_W'(KEEP_MIN) && mem_rd_data < limit_reg)
                begin
                    cur_ptr_next = ptr_inc(cur_ptr_reg);
                    cur_cnt_next = cur_cnt_reg - CNT_W'(1);
                    state_next   = ST_SCAN_RD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    res_avg_next = div_quotient;
                    res_cnt_next = cur_cnt_reg;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            window_reg    <= WIN_W'(WINDOW_RESET);
            for (int i = 0; i < STREAM_COUNT; i++)
            begin
                ptr_arr[i] <= '0;
                cnt_arr[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && paddr[PADDR_W-1] == REG_WINDOW)
            begin
                window_reg <= pwdata[WIN_W-1:0];
            end
            if (clear_all)
            begin
                for (int i = 0; i < STREAM_COUNT; i++)
                begin
                    ptr_arr[i] <= '0;
                    cnt_arr[i] <= '0;
                end
            end
            else if (active_reg && state_reg != ST_IDLE)
            begin
                ptr_arr[stream_reg] <= cur_ptr_next;
                cnt_arr[stream_reg] <= cur_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg   <= limit_next;
        cur_ptr_reg <= cur_ptr_next;
        cur_cnt_reg <= cur_cnt_next;
        res_avg_reg <= res_avg_next;
        res_cnt_reg <= res_cnt_next;
        if (in_accept)
        begin
            stream_reg <= in_sidx;
            now_reg    <= now_ms;
        end
        if (out_load)
        begin
            avg_reg  <= res_avg_reg;
            kept_reg <= KEPT_W'(res_cnt_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign avg_interval = avg_reg;
    assign kept_count   = kept_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[PADDR_W-1] == REG_WINDOW) ? PDATA_W'(window_reg) : '0;

    // an accepted item keeps the input stalled until its result is loaded
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled after item accepted");

    // fewer than two kept entries give a zero interval
    a_lone_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kept_count > KEPT_W'(1) || avg_interval == '0))
        else $error("nonzero interval with fewer than two entries");

    // kept count never exceeds ring depth
    a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kept_count <= KEPT_W'(RING_DEPTH))
        else $error("kept count beyond ring depth");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider done outside wait state");

endmodule

// ----- rtl/weia_store.sv -----
// timestamp memory, one write port and one registered read port
// depends on weia_pkg

module weia_store
    import weia_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [TIME_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [TIME_W-1:0] rd_data
);

    logic [TIME_W-1:0] mem [STORE_DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/weia_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on weia_pkg

module weia_div
    import weia_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic [AVG_W-1:0]  quotient,
    output div_stat_t         stat
);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] divr_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVR_W:0]   shifted;
    logic [DIVR_W:0]   diff;
    logic              fits;

    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = shifted - {1'b0, divr_reg};
        fits      = shifted >= {1'b0, divr_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], fits};
            rem_next  = fits ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
        begin
            divr_reg <= divisor;
        end
    end

    assign quotient  = dvd_reg[AVG_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
